### hw/rtl/force_frame_parser_top_defines.svh
// assertion macros for the force frame parser
// used by force_frame_parser_top; expects clk and rst_n in scope
`ifndef FORCE_FRAME_PARSER_TOP_DEFINES_SVH
`define FORCE_FRAME_PARSER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFP_ASSERT_IMP(label, ante, cons, msg)
`define FFP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/ffp_pkg.sv
// shared constants, command/status types and crc helper for the force frame parser
// no dependencies
package ffp_pkg;

    localparam int FRAME_BYTES  = 28;
    localparam int COUNTER_BITS = 32;
    localparam int CRC_LEN      = 26;
    localparam int FILL_BITS    = $clog2(FRAME_BYTES + 1);
    localparam int IDX_BITS     = $clog2(FRAME_BYTES);

    localparam logic [7:0]  HDR0     = 8'h53;
    localparam logic [7:0]  HDR1     = 8'h54;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_GOOD      = 2'd1;
    localparam logic [1:0] EV_CRC       = 2'd2;
    localparam logic [1:0] EV_NONFINITE = 2'd3;

    typedef logic [COUNTER_BITS-1:0] cnt_t;
    typedef logic [FILL_BITS-1:0]    fill_t;

    typedef struct packed {
        logic store;
        logic drop;
        logic crc_init;
        logic crc_step;
        logic crc_fail;
        logic frame_done;
        logic load_out;
    } ffp_cmd_t;

    typedef struct packed {
        logic fill_ge2;
        logic full;
        logic hdr_ok;
        logic crc_last;
        logic crc_match;
        logic out_free;
    } ffp_stat_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == '1) ? c : c + cnt_t'(1);
    endfunction

endpackage

### hw/rtl/ffp_rx_if.sv
// byte input channel of the force frame parser
// no dependencies
interface ffp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/ffp_res_if.sv
// result channel of the force frame parser
// no dependencies
interface ffp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [31:0] moment_x;
    logic [31:0] moment_y;
    logic [31:0] moment_z;
    logic [31:0] good_frames;
    logic [31:0] crc_failures;
    logic [31:0] skipped_bytes;
    logic [31:0] bad_value_frames;

    modport source (output valid, output event_res, output force_x, output force_y,
                    output force_z, output moment_x, output moment_y, output moment_z,
                    output good_frames, output crc_failures, output skipped_bytes,
                    output bad_value_frames, input ready);
    modport sink (input valid, input event_res, input force_x, input force_y,
                  input force_z, input moment_x, input moment_y, input moment_z,
                  input good_frames, input crc_failures, input skipped_bytes,
                  input bad_value_frames, output ready);
endinterface

### hw/rtl/ffp_ctrl.sv
// sequencer of the force frame parser: header hunt, crc pass, result hand-off
// depends on ffp_pkg
module ffp_ctrl
    import ffp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_ready,
    input  ffp_stat_t stat,
    output ffp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign rx_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.fill_ge2)
                begin
                    state_next = ST_OUT;
                end
                else if (!stat.hdr_ok)
                begin
                    cmd.drop = 1'b1;
                end
                else if (!stat.full)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.crc_init = 1'b1;
                    state_next   = ST_CRC;
                end
            end
            ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (stat.crc_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.crc_match)
                begin
                    cmd.frame_done = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    // drop one byte and hunt for the next header
                    cmd.crc_fail = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/ffp_datapath.sv
// byte window, crc engine, saturating counters and result register
// depends on ffp_pkg and ffp_res_if
module ffp_datapath
    import ffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  ffp_cmd_t    cmd,
    output ffp_stat_t   stat,
    ffp_res_if.source   res
);

    logic [7:0]          window_reg [FRAME_BYTES];
    fill_t               fill_reg;
    logic [IDX_BITS-1:0] crc_idx_reg;
    logic [15:0]         crc_reg;
    logic [1:0]          event_reg;
    cnt_t                good_reg;
    cnt_t                crc_fail_reg;
    cnt_t                skip_reg;
    cnt_t                nonfinite_reg;
    logic                out_valid_reg;
    logic [1:0]          out_event_reg;
    logic [31:0]         out_word_reg [6];
    logic [31:0]         out_good_reg;
    logic [31:0]         out_crc_reg;
    logic [31:0]         out_skip_reg;
    logic [31:0]         out_nonfin_reg;

    logic [31:0] words [6];
    logic        finite;

    always_comb
    begin
        finite = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            words[k] = {window_reg[2 + 4 * k + 3], window_reg[2 + 4 * k + 2],
                        window_reg[2 + 4 * k + 1], window_reg[2 + 4 * k]};
            if (words[k][30:23] == 8'hFF)
            begin
                finite = 1'b0;
            end
        end
    end

    assign stat.fill_ge2  = (fill_reg >= fill_t'(2));
    assign stat.full      = (fill_reg >= fill_t'(FRAME_BYTES));
    assign stat.hdr_ok    = (window_reg[0] == HDR0) && (window_reg[1] == HDR1);
    assign stat.crc_last  = (crc_idx_reg == IDX_BITS'(CRC_LEN - 1));
    assign stat.crc_match = (crc_reg == {window_reg[CRC_LEN + 1], window_reg[CRC_LEN]});
    assign stat.out_free  = !out_valid_reg || res.ready;

    // window payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            window_reg[fill_reg[IDX_BITS-1:0]] <= rx_byte;
        end
        else if (cmd.drop || cmd.crc_fail)
        begin
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            crc_idx_reg   <= '0;
            crc_reg       <= CRC_INIT;
            event_reg     <= EV_NONE;
            good_reg      <= '0;
            crc_fail_reg  <= '0;
            skip_reg      <= '0;
            nonfinite_reg <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                fill_reg  <= fill_reg + fill_t'(1);
                event_reg <= EV_NONE;
            end
            if (cmd.drop)
            begin
                fill_reg <= fill_reg - fill_t'(1);
                skip_reg <= sat_inc(skip_reg);
            end
            if (cmd.crc_fail)
            begin
                fill_reg     <= fill_reg - fill_t'(1);
                skip_reg     <= sat_inc(skip_reg);
                crc_fail_reg <= sat_inc(crc_fail_reg);
                event_reg    <= EV_CRC;
            end
            if (cmd.crc_init)
            begin
                crc_reg     <= CRC_INIT;
                crc_idx_reg <= '0;
            end
            if (cmd.crc_step)
            begin
                crc_reg     <= crc16_byte(crc_reg, window_reg[crc_idx_reg]);
                crc_idx_reg <= crc_idx_reg + IDX_BITS'(1);
            end
            if (cmd.frame_done)
            begin
                fill_reg <= '0;
                if (finite)
                begin
                    good_reg  <= sat_inc(good_reg);
                    event_reg <= EV_GOOD;
                end
                else
                begin
                    nonfinite_reg <= sat_inc(nonfinite_reg);
                    event_reg     <= EV_NONFINITE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // frame bytes stay in the window after a good frame until the next transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_event_reg  <= event_reg;
            for (int k = 0; k < 6; k++)
            begin
                out_word_reg[k] <= (event_reg == EV_GOOD) ? words[k] : 32'd0;
            end
            out_good_reg   <= 32'(good_reg);
            out_crc_reg    <= 32'(crc_fail_reg);
            out_skip_reg   <= 32'(skip_reg);
            out_nonfin_reg <= 32'(nonfinite_reg);
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.event_res        = out_event_reg;
    assign res.force_x          = out_word_reg[0];
    assign res.force_y          = out_word_reg[1];
    assign res.force_z          = out_word_reg[2];
    assign res.moment_x         = out_word_reg[3];
    assign res.moment_y         = out_word_reg[4];
    assign res.moment_z         = out_word_reg[5];
    assign res.good_frames      = out_good_reg;
    assign res.crc_failures     = out_crc_reg;
    assign res.skipped_bytes    = out_skip_reg;
    assign res.bad_value_frames = out_nonfin_reg;

endmodule

### hw/rtl/force_frame_parser_top.sv
// force frame parser: byte in, one result per byte out
// depends on ffp_pkg, ffp_rx_if, ffp_res_if, ffp_ctrl, ffp_datapath
//
// usage:
//   rx carries one received link byte per transfer (valid/ready).
//   res carries exactly one result per input byte: event code, the six raw
//   float32 words (nonzero only for a good frame) and four saturating counters.
// timing:
//   a byte that does not complete a 28-byte window passes the scan and hand-off
//   steps; the scan step drops bytes one at a time while hunting for the 0x53 0x54 header.
//   a byte that completes a window runs the crc unit one byte per cycle over
//   26 bytes; after a crc mismatch one byte is dropped and the header hunt
//   resumes.
//   the result lands in an output register, so the next byte is taken while
//   the previous result still waits; a stalled receiver holds the block in its
//   hand-off step until res.ready comes back.
// reset:
//   window is emptied and all counters cleared; no clearing pass is needed.
module force_frame_parser_top
    import ffp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ffp_rx_if.sink     rx,
    ffp_res_if.source  res
);

`include "force_frame_parser_top_defines.svh"

    ffp_cmd_t  cmd;
    ffp_stat_t stat;

    ffp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffp_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res)
    );

    `FFP_ASSERT_NXT(a_one_in_flight, rx.valid && rx.ready, !rx.ready, "byte taken while busy")
    `FFP_ASSERT_IMP(a_store_room, cmd.store, !stat.full, "byte stored into full window")
    `FFP_ASSERT_IMP(a_words_only_good, res.valid && (res.event_res != EV_GOOD), (res.force_x == 32'd0) && (res.moment_z == 32'd0), "frame words on non-good result")
    `FFP_ASSERT_IMP(a_crc_needs_full, cmd.crc_init, stat.hdr_ok && stat.full, "crc pass without full framed window")

endmodule
